FILE: rtl/core/mmpn_pkg.sv
`default_nettype none

package mmpn_pkg;

	// default geometry
	localparam int MAX_SLOTS_DEF  = 256;
	localparam int PAGE_SHIFT_DEF = 12;

	localparam int CAP_W = 9;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;

	// bootloader type codes
	localparam logic [31:0] TYPE_AVAILABLE = 32'd1;
	localparam logic [31:0] TYPE_ACPI      = 32'd3;
	localparam logic [31:0] TYPE_NVS       = 32'd4;
	localparam logic [31:0] TYPE_BAD       = 32'd5;

	// memory classes
	localparam logic [2:0] CLASS_CONVENTIONAL = 3'd0;
	localparam logic [2:0] CLASS_ACPI_RECLAIM = 3'd1;
	localparam logic [2:0] CLASS_ACPI_NVS     = 3'd2;
	localparam logic [2:0] CLASS_UNUSABLE     = 3'd3;
	localparam logic [2:0] CLASS_RESERVED     = 3'd4;

	// outcome codes
	localparam logic [1:0] OUT_STORED        = 2'd0;
	localparam logic [1:0] OUT_EMPTY         = 2'd1;
	localparam logic [1:0] OUT_ALIGNED_EMPTY = 2'd2;
	localparam logic [1:0] OUT_FULL          = 2'd3;

	typedef struct packed {
		logic        first_entry;
		logic [63:0] region_base;
		logic [63:0] region_length;
		logic [31:0] raw_type;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  outcome;
		logic [2:0]  mem_class;
		logic [63:0] page_start;
		logic [51:0] page_count;
		logic [7:0]  slot_index;
		logic [8:0]  stored_total;
		logic [63:0] top_of_memory;
	} out_item_t;

	// first stage: raw entry with its end address and class
	typedef struct packed {
		logic        first_entry;
		logic        degenerate;
		logic [2:0]  mem_class;
		logic [63:0] base;
		logic [63:0] end_addr;
	} s1_t;

	// second stage: page-aligned bounds
	typedef struct packed {
		logic        first_entry;
		logic [1:0]  geom_outcome;
		logic [2:0]  mem_class;
		logic [63:0] start_addr;
		logic [63:0] end_addr;
	} s2_t;

	function automatic logic [2:0] class_of(input logic [31:0] raw);
		logic [2:0] cls;
		unique case (raw)
			TYPE_AVAILABLE: cls = CLASS_CONVENTIONAL;
			TYPE_ACPI:      cls = CLASS_ACPI_RECLAIM;
			TYPE_NVS:       cls = CLASS_ACPI_NVS;
			TYPE_BAD:       cls = CLASS_UNUSABLE;
			default:        cls = CLASS_RESERVED;
		endcase
		return cls;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mmpn_align.sv
`default_nettype none

module mmpn_align
	import mmpn_pkg::*;
#(
	parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
	input  wire s1_t s1,
	output s2_t      s2
);

	localparam logic [63:0] LOW_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

	logic [63:0] base_up;
	logic [63:0] end_up;
	logic        usable;

	// usable memory shrinks inward, everything else grows outward
	assign usable  = (s1.mem_class == CLASS_CONVENTIONAL);
	assign base_up = (s1.base + LOW_MASK) & ~LOW_MASK;
	assign end_up  = (s1.end_addr + LOW_MASK) & ~LOW_MASK;

	always_comb begin
		s2.first_entry = s1.first_entry;
		s2.mem_class   = s1.mem_class;
		if (usable) begin
			s2.start_addr = base_up;
			s2.end_addr   = s1.end_addr & ~LOW_MASK;
		end else begin
			s2.start_addr = s1.base & ~LOW_MASK;
			s2.end_addr   = end_up;
		end
		if (s1.degenerate) begin
			s2.geom_outcome = OUT_EMPTY;
		end else if (usable ? (s2.end_addr <= s2.start_addr)
				: (s2.end_addr < s2.start_addr)) begin
			s2.geom_outcome = OUT_ALIGNED_EMPTY;
		end else begin
			s2.geom_outcome = OUT_STORED;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/memory_map_page_normalizer_unit.sv
`default_nettype none
// Memory map page normalizer.
// Input channel (in_valid / in_stall / in_data): one raw memory map entry per
// transfer. Output channel (out_valid / out_stall / out_data): exactly one
// result per entry, in arrival order.
// Config: cfg_we with cfg_wdata writes the slot capacity; write only while
// the pipeline is empty. The effective limit is min(capacity, MAX_SLOTS).
// Pipeline: input register (end address, class), then page rounding and slot
// allocation in one combinational pass into the result register (count,
// highest end). A transfer accepted into the input register shows its result
// on out_data once it moves on into the result register.
// Throughput: one entry per cycle when out_stall stays low; the slot count
// and highest end update as the result is registered, so back-to-back
// entries see each other's effects without bubbles.
// Out stall: backpressure goes straight back to the input; a full pipeline
// raises in_stall in the same cycle that out_stall holds the result.
// Reset: arst_n clears valids, stored count, stop flag, highest end, and
// restores capacity to 256.

module memory_map_page_normalizer_unit
	import mmpn_pkg::*;
#(
	parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
	parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_we,
	input  wire [CAP_W-1:0] cfg_wdata,
	input  wire             in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire             out_stall,
	output out_item_t       out_data
);

	// count holds 0..MAX_SLOTS
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int WW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0] capacity_q;
	logic [CW-1:0]    count_q;
	logic             stopped_q;
	logic [63:0]      highest_q;

	logic s1_valid_s1;
	s1_t  item_s1;
	s1_t  s1_d;
	s2_t  s2_d;

	logic out_adv, s1_ready;
	logic s1_move, in_take;

	// handshake chain
	assign out_adv  = !out_valid || !out_stall;
	assign s1_ready = !s1_valid_s1 || out_adv;
	assign in_stall = !s1_ready;
	assign in_take  = in_valid && s1_ready;
	assign s1_move  = s1_valid_s1 && out_adv;

	// input stage: end address and wrap check
	logic [64:0] sum_w;
	assign sum_w = {1'b0, in_data.region_base} + {1'b0, in_data.region_length};

	always_comb begin
		s1_d.first_entry = in_data.first_entry;
		s1_d.degenerate  = (in_data.region_length == 64'd0) || sum_w[64];
		s1_d.mem_class   = class_of(in_data.raw_type);
		s1_d.base        = in_data.region_base;
		s1_d.end_addr    = sum_w[63:0];
	end

	mmpn_align #(
		.PAGE_SHIFT(PAGE_SHIFT)
	) u_align (
		.s1(item_s1),
		.s2(s2_d)
	);

	// result logic: slot allocation against the running state
	logic [CW-1:0] eff_count;
	logic          eff_stop;
	logic [63:0]   eff_high;
	logic [WW-1:0] limit_w, cap_w, cnt_w;
	logic [1:0]    outcome;
	logic [CW-1:0] count_n;
	logic          stop_n;
	logic [63:0]   high_n;
	logic [63:0]   span;
	logic [63:0]   pages_w;
	logic [WW-1:0] total_w;
	out_item_t     out_d;

	always_comb begin
		eff_count = s2_d.first_entry ? '0 : count_q;
		eff_stop  = s2_d.first_entry ? 1'b0 : stopped_q;
		eff_high  = s2_d.first_entry ? 64'd0 : highest_q;
		cap_w     = WW'(capacity_q);
		limit_w   = (cap_w < WW'(MAX_SLOTS)) ? cap_w : WW'(MAX_SLOTS);
		cnt_w     = WW'(eff_count);
		count_n   = eff_count;
		stop_n    = eff_stop;
		high_n    = eff_high;

		if (eff_stop) begin
			outcome = OUT_FULL;
		end else if (s2_d.geom_outcome != OUT_STORED) begin
			outcome = s2_d.geom_outcome;
		end else if (cnt_w >= limit_w) begin
			outcome = OUT_FULL;
			stop_n  = 1'b1;
		end else begin
			outcome = OUT_STORED;
		end

		span    = s2_d.end_addr - s2_d.start_addr;
		pages_w = span >> PAGE_SHIFT;

		if (outcome == OUT_STORED) begin
			count_n = eff_count + CW'(1);
			if (s2_d.mem_class <= CLASS_ACPI_NVS && s2_d.end_addr > eff_high) begin
				high_n = s2_d.end_addr;
			end
		end
		total_w = WW'(count_n);

		out_d.outcome       = outcome;
		out_d.mem_class     = s2_d.mem_class;
		out_d.page_start    = (outcome == OUT_STORED) ? s2_d.start_addr : 64'd0;
		out_d.page_count    = (outcome == OUT_STORED) ? pages_w[51:0] : 52'd0;
		out_d.slot_index    = (outcome == OUT_STORED) ? cnt_w[7:0] : 8'd0;
		out_d.stored_total  = total_w[8:0];
		out_d.top_of_memory = high_n;
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAPACITY_RESET;
			count_q     <= '0;
			stopped_q   <= 1'b0;
			highest_q   <= 64'd0;
			s1_valid_s1 <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (s1_ready) begin
				s1_valid_s1 <= in_valid;
			end
			if (out_adv) begin
				out_valid <= s1_valid_s1;
			end
			if (s1_move) begin
				count_q   <= count_n;
				stopped_q <= stop_n;
				highest_q <= high_n;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= s1_d;
		end
		if (s1_move) begin
			out_data <= out_d;
		end
	end

endmodule

`default_nettype wire
